### rtl/cdpa_pkg.sv
// cdpa_pkg: types and constants shared by the colour distance projection search
// no dependencies
package cdpa_pkg;
    localparam int SUM_W = 24;
    localparam int D2_W  = 18;
    localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

    typedef enum logic [2:0] {
        REG_REF_L = 3'd0, REG_REF_A = 3'd1, REG_REF_B = 3'd2, REG_WXF = 3'd3,
        REG_WXE = 3'd4, REG_WYF = 3'd5, REG_WYE = 3'd6, REG_MODE = 3'd7
    } t_reg_idx;

    typedef struct packed {
        logic [7:0]  ref_l;
        logic [7:0]  ref_a;
        logic [7:0]  ref_b;
        logic [10:0] wxf;
        logic [11:0] wxe;
        logic [10:0] wyf;
        logic [11:0] wye;
        logic        mode;
    } t_cfg;

    function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] a,
                                                 input logic [SUM_W-1:0] b);
        logic [SUM_W:0] t;
        t = {1'b0, a} + {1'b0, b};
        return t[SUM_W] ? SUM_MAX : t[SUM_W-1:0];
    endfunction
endpackage

### rtl/cdpa_sqrt.sv
// cdpa_sqrt: pipelined restoring square root, two result bits per stage pair
// depends on cdpa_pkg
module cdpa_sqrt import cdpa_pkg::*; #(
    parameter int IN_W = 26,
    parameter int TAG_W = 1
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_vld,
    input  logic [IN_W-1:0]        i_val,
    input  logic [TAG_W-1:0]       i_tag,
    output logic                   o_vld,
    output logic [(IN_W+1)/2-1:0]  o_root,
    output logic [TAG_W-1:0]       o_tag
);
    localparam int N = (IN_W + 1) / 2;
    localparam int VW = 2 * N;
    logic [N:1]            r_vld;
    logic [VW-1:0]         r_rem [1:N];
    logic [VW-1:0]         r_val [1:N];
    logic [N-1:0]          r_res [1:N];
    logic [TAG_W-1:0]      r_tag [1:N];

    for (genvar s = 0; s < N; s++) begin : g_st
        logic             n_vin;
        logic [VW-1:0]    n_rin;
        logic [VW-1:0]    n_xin;
        logic [N-1:0]     n_sin;
        logic [TAG_W-1:0] n_tin;
        logic [VW+1:0]    n_trial;
        logic [VW+1:0]    n_rem;
        if (s == 0) begin : g_head
            assign n_vin = i_vld;
            assign n_rin = '0;
            assign n_xin = VW'(i_val);
            assign n_sin = '0;
            assign n_tin = i_tag;
        end else begin : g_link
            assign n_vin = r_vld[s];
            assign n_rin = r_rem[s];
            assign n_xin = r_val[s];
            assign n_sin = r_res[s];
            assign n_tin = r_tag[s];
        end
        always_comb begin
            n_rem   = {n_rin, n_xin[VW-1 -: 2]};
            n_trial = n_rem - {{(VW+2-N-2){1'b0}}, n_sin, 2'b01};
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[s+1] <= 1'b0;
            end else begin
                r_vld[s+1] <= n_vin;
            end
            r_val[s+1] <= n_xin << 2;
            r_tag[s+1] <= n_tin;
            if (!n_trial[VW+1]) begin
                r_rem[s+1] <= n_trial[VW-1:0];
                r_res[s+1] <= {n_sin[N-2:0], 1'b1};
            end else begin
                r_rem[s+1] <= n_rem[VW-1:0];
                r_res[s+1] <= {n_sin[N-2:0], 1'b0};
            end
        end
    end
    assign o_vld  = r_vld[N];
    assign o_root = r_res[N];
    assign o_tag  = r_tag[N];
endmodule

### rtl/cdpa_accum.sv
// cdpa_accum: column sum memory read-modify-write, row sum and running minimum
// depends on cdpa_pkg
module cdpa_accum import cdpa_pkg::*; #(
    parameter int COL_W = 11
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_vld,
    input  logic [SUM_W-1:0]  i_d,
    input  logic              i_in,
    input  logic              i_first,
    input  logic              i_last,
    input  logic              i_mode,
    input  logic [10:0]       i_col,
    input  logic [10:0]       i_row,
    input  logic              i_fend,
    output logic              o_vld,
    output logic [10:0]       o_pos,
    output logic [SUM_W-1:0]  o_sum,
    output logic              o_found
);
    logic [SUM_W-1:0] mem [2**COL_W];
    logic [SUM_W-1:0] r_rd;
    logic             r_vld, r_in, r_first, r_last, r_mode, r_fend;
    logic [SUM_W-1:0] r_d;
    logic [10:0]      r_col, r_row;
    logic             r_wv;
    logic [10:0]      r_wcol;
    logic [SUM_W-1:0] r_wdat;
    logic [SUM_W-1:0] r_row_sum, r_min_sum;
    logic [10:0]      r_min_pos;
    logic             r_have;
    logic [SUM_W-1:0] n_old, n_s, n_rs, n_line;
    logic [10:0]      n_lpos;
    logic             n_offer, n_take;

    always_ff @(posedge i_clk) begin
        r_rd <= mem[i_col[COL_W-1:0]];
        if (r_vld && r_in && !r_mode) mem[r_col[COL_W-1:0]] <= n_s;
    end

    always_comb begin
        n_old  = (r_wv && r_wcol == r_col) ? r_wdat : r_rd;
        n_s    = r_first ? r_d : sat_add(n_old, r_d);
        n_rs   = r_first ? r_d : sat_add(r_row_sum, r_d);
        n_line = r_mode ? n_rs : n_s;
        n_lpos = r_mode ? r_row : r_col;
        n_offer = r_vld && r_in && r_last;
        n_take  = n_offer && (!r_have || n_line < r_min_sum);
    end

    always_ff @(posedge i_clk) begin
        r_d <= i_d; r_in <= i_in; r_first <= i_first; r_last <= i_last;
        r_mode <= i_mode; r_col <= i_col; r_row <= i_row; r_fend <= i_fend;
        r_wcol <= r_col; r_wdat <= n_s;
        o_pos <= n_take ? n_lpos : (r_have ? r_min_pos : 11'd0);
        o_sum <= n_take ? n_line : (r_have ? r_min_sum : '0);
        o_found <= n_take || r_have;
        if (!i_rst_n) begin
            r_vld <= 1'b0; r_wv <= 1'b0; o_vld <= 1'b0;
            r_row_sum <= '0; r_min_sum <= SUM_MAX; r_min_pos <= '0; r_have <= 1'b0;
        end else begin
            r_vld <= i_vld;
            r_wv  <= r_vld && r_in && !r_mode;
            o_vld <= r_vld && r_fend;
            if (r_vld && r_in && r_mode) r_row_sum <= n_rs;
            if (n_take) begin
                r_min_sum <= n_line; r_min_pos <= n_lpos; r_have <= 1'b1;
            end
            if (r_vld && r_fend) begin
                r_row_sum <= '0; r_min_sum <= SUM_MAX; r_min_pos <= '0; r_have <= 1'b0;
            end
        end
    end
endmodule

### rtl/color_distance_projection_argmin.sv
// color_distance_projection_argmin: top level, config registers, distance and output stage
// depends on cdpa_pkg, cdpa_sqrt, cdpa_accum
// One pixel request is taken per clock while the result register is free. The distance goes
// through a pipelined square root of (D2_W + 2*FRAC_BITS + 1)/2 stages, then a registered
// column memory read and a write-back with forwarding. Input stalls while a result waits
// or is in flight.
module color_distance_projection_argmin import cdpa_pkg::*; #(
    parameter int MAX_COLS = 2048,
    parameter int MAX_ROWS = 2048,
    parameter int FRAC_BITS = 4
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_valid,
    output logic         o_stall,
    input  logic [7:0]   i_pix_l,
    input  logic [7:0]   i_pix_a,
    input  logic [7:0]   i_pix_b,
    input  logic [10:0]  i_col,
    input  logic [10:0]  i_row,
    input  logic         i_frame_end,
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic [2:0]   i_cfg_index,
    input  logic [11:0]  i_cfg_data,
    output logic         o_valid,
    input  logic         i_stall,
    output logic [10:0]  o_best_pos,
    output logic [23:0]  o_best_sum,
    output logic         o_found
);
    localparam int COL_W = (MAX_COLS > 2048) ? 11 : $clog2(MAX_COLS);
    localparam int SQ_IN = D2_W + 2 * FRAC_BITS;
    localparam int SQ_OUT = (SQ_IN + 1) / 2;
    localparam int TAG_W = 27;

    t_cfg r_cfg;
    logic r_busy;
    logic r_vld1, r_vld0;
    logic [D2_W-1:0] r_d2;
    logic [TAG_W-1:0] r_tag0;
    logic [TAG_W-1:0] r_tag1;
    logic signed [8:0] n_dl, n_da, n_db;
    logic [TAG_W-1:0] n_tag, s_tag;
    logic n_inside, s_vld, a_vld, a_found;
    logic [SQ_OUT-1:0] s_root;
    logic [SUM_W-1:0] s_d, a_sum;
    logic [10:0] a_pos;
    logic [15:0] sq_l, sq_a, sq_b;
    logic acc;

    assign o_cfg_ready = 1'b1;
    assign acc = i_valid && !o_stall;
    assign o_stall = r_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '{ref_l: 8'd0, ref_a: 8'd0, ref_b: 8'd0, wxf: 11'd0, wxe: 12'd2048,
                       wyf: 11'd0, wye: 12'd2048, mode: 1'b0};
        end else if (i_cfg_valid) begin
            case (t_reg_idx'(i_cfg_index))
                REG_REF_L: r_cfg.ref_l <= i_cfg_data[7:0];
                REG_REF_A: r_cfg.ref_a <= i_cfg_data[7:0];
                REG_REF_B: r_cfg.ref_b <= i_cfg_data[7:0];
                REG_WXF:   r_cfg.wxf <= i_cfg_data[10:0];
                REG_WXE:   r_cfg.wxe <= i_cfg_data;
                REG_WYF:   r_cfg.wyf <= i_cfg_data[10:0];
                REG_WYE:   r_cfg.wye <= i_cfg_data;
                REG_MODE:  r_cfg.mode <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        n_dl = $signed({1'b0, i_pix_l}) - $signed({1'b0, r_cfg.ref_l});
        n_da = $signed({1'b0, i_pix_a}) - $signed({1'b0, r_cfg.ref_a});
        n_db = $signed({1'b0, i_pix_b}) - $signed({1'b0, r_cfg.ref_b});
        n_inside = i_col >= r_cfg.wxf && {1'b0, i_col} < r_cfg.wxe &&
                   i_row >= r_cfg.wyf && {1'b0, i_row} < r_cfg.wye &&
                   32'(i_col) < MAX_COLS && 32'(i_row) < MAX_ROWS;
        n_tag = {n_inside,
                 r_cfg.mode ? (i_col == r_cfg.wxf) : (i_row == r_cfg.wyf),
                 r_cfg.mode ? ({1'b0, i_col} + 12'd1 == r_cfg.wxe)
                            : ({1'b0, i_row} + 12'd1 == r_cfg.wye),
                 r_cfg.mode, i_col, i_row, i_frame_end};
    end

    always_ff @(posedge i_clk) begin
        sq_l <= 16'(n_dl * n_dl);
        sq_a <= 16'(n_da * n_da);
        sq_b <= 16'(n_db * n_db);
        r_tag1 <= r_tag0;
        r_d2 <= D2_W'(sq_l) + D2_W'(sq_a) + D2_W'(sq_b);
        if (!i_rst_n) begin
            r_vld0 <= 1'b0; r_vld1 <= 1'b0;
        end else begin
            r_vld0 <= acc; r_vld1 <= r_vld0;
        end
    end
    always_ff @(posedge i_clk) r_tag0 <= n_tag;

    cdpa_sqrt #(.IN_W(SQ_IN), .TAG_W(TAG_W)) u_sqrt (
        .i_clk, .i_rst_n, .i_vld(r_vld1), .i_val({r_d2, {(2*FRAC_BITS){1'b0}}}),
        .i_tag(r_tag1), .o_vld(s_vld), .o_root(s_root), .o_tag(s_tag));

    assign s_d = (SQ_OUT > SUM_W) ? SUM_MAX : SUM_W'(s_root);

    cdpa_accum #(.COL_W(COL_W)) u_acc (
        .i_clk, .i_rst_n, .i_vld(s_vld), .i_d(s_d), .i_in(s_tag[26]), .i_first(s_tag[25]),
        .i_last(s_tag[24]), .i_mode(s_tag[23]), .i_col(s_tag[22:12]), .i_row(s_tag[11:1]),
        .i_fend(s_tag[0]), .o_vld(a_vld), .o_pos(a_pos), .o_sum(a_sum), .o_found(a_found));

    always_ff @(posedge i_clk) begin
        if (a_vld) begin
            o_best_pos <= a_pos; o_best_sum <= a_sum; o_found <= a_found;
        end
        if (!i_rst_n) begin
            o_valid <= 1'b0; r_busy <= 1'b0;
        end else begin
            if (a_vld) o_valid <= 1'b1;
            else if (!i_stall) o_valid <= 1'b0;
            if (acc && i_frame_end) r_busy <= 1'b1;
            else if (o_valid && !i_stall) r_busy <= 1'b0;
        end
    end
endmodule

### rtl/cdpa_checker.sv
// cdpa_checker: port level assertions for the top level, with bind
// depends on color_distance_projection_argmin ports
module cdpa_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_stall,
    input logic        o_valid,
    input logic        i_stall,
    input logic [10:0] o_best_pos,
    input logic [23:0] o_best_sum,
    input logic        o_found
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_best_sum))
        else $error("stalled result changed");
    a_nf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_found |-> o_best_sum == 24'd0 && o_best_pos == 11'd0)
        else $error("empty result not zero");
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_stall)
        else $error("input open while result pending");
endmodule

bind color_distance_projection_argmin cdpa_checker u_chk (.*);

### tb/color_distance_projection_argmin_test.sv
// color_distance_projection_argmin_test: self-checking bench for the color distance argmin search
// predicts per-pixel distances, line sums and the frame-end result, compares each result
// depends on cdpa_pkg and color_distance_projection_argmin
module color_distance_projection_argmin_test;
    import cdpa_pkg::*;

    typedef struct {
        logic [10:0] pos;
        logic [23:0] sum;
        logic        found;
    } t_best_line;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic [7:0]  i_pix_l;
    logic [7:0]  i_pix_a;
    logic [7:0]  i_pix_b;
    logic [10:0] i_col;
    logic [10:0] i_row;
    logic        i_frame_end;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index;
    logic [11:0] i_cfg_data;
    logic        o_valid;
    logic        i_stall;
    logic [10:0] o_best_pos;
    logic [23:0] o_best_sum;
    logic        o_found;

    color_distance_projection_argmin u_top (.*);

    t_cfg        cfg_shadow;
    logic [23:0] col_sum_shadow [2048];
    bit          col_written [2048];
    logic [23:0] row_sum_shadow;
    logic [23:0] min_sum_shadow;
    logic [10:0] min_pos_shadow;
    logic        have_min_shadow;
    t_best_line  best_line_q [$];

    int  mismatch_count = 0;
    int  sender_idle_pct = 0;
    int  stall_pct = 0;
    int  hold_left = 0;
    int  pixels_sent = 0;
    bit  pixel_taken = 0;
    bit  cfg_taken = 0;

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #20000000;
        $display("color_distance_projection_argmin verification failed");
        $finish;
    end

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        mismatch_count++;
    endtask

    function automatic logic [23:0] pixel_distance(input logic [7:0] l, input logic [7:0] a,
                                                   input logic [7:0] b);
        longint dl, da, db, v, res, bit_w;
        dl = longint'(l) - longint'(cfg_shadow.ref_l);
        da = longint'(a) - longint'(cfg_shadow.ref_a);
        db = longint'(b) - longint'(cfg_shadow.ref_b);
        v = (dl * dl + da * da + db * db) << 8;
        res = 0;
        bit_w = longint'(1) << 60;
        while (bit_w > v) bit_w = bit_w >> 2;
        while (bit_w != 0) begin
            if (v >= res + bit_w) begin
                v = v - (res + bit_w);
                res = (res >> 1) + bit_w;
            end else begin
                res = res >> 1;
            end
            bit_w = bit_w >> 2;
        end
        return (res > 24'hFFFFFF) ? 24'hFFFFFF : res[23:0];
    endfunction

    function automatic bit in_window(input logic [10:0] c, input logic [10:0] r);
        return {1'b0, c} >= {1'b0, cfg_shadow.wxf} && {1'b0, c} < cfg_shadow.wxe &&
               {1'b0, r} >= {1'b0, cfg_shadow.wyf} && {1'b0, r} < cfg_shadow.wye;
    endfunction

    function automatic logic [23:0] add_clamped(input logic [23:0] s, input logic [23:0] d);
        logic [24:0] t;
        t = {1'b0, s} + {1'b0, d};
        return t[24] ? 24'hFFFFFF : t[23:0];
    endfunction

    task automatic offer_line(input logic [23:0] s, input logic [10:0] p);
        if (!have_min_shadow || s < min_sum_shadow) begin
            min_sum_shadow = s;
            min_pos_shadow = p;
            have_min_shadow = 1;
        end
    endtask

    task automatic apply_pixel();
        logic [23:0] d;
        logic [23:0] s;
        t_best_line  res;
        if (in_window(i_col, i_row)) begin
            d = pixel_distance(i_pix_l, i_pix_a, i_pix_b);
            if (!cfg_shadow.mode) begin
                s = ({1'b0, i_row} == {1'b0, cfg_shadow.wyf}) ? d
                    : add_clamped(col_sum_shadow[i_col], d);
                col_sum_shadow[i_col] = s;
                col_written[i_col] = 1;
                if ({1'b0, i_row} + 12'd1 == cfg_shadow.wye) offer_line(s, i_col);
            end else begin
                row_sum_shadow = ({1'b0, i_col} == {1'b0, cfg_shadow.wxf}) ? d
                    : add_clamped(row_sum_shadow, d);
                if ({1'b0, i_col} + 12'd1 == cfg_shadow.wxe) offer_line(row_sum_shadow, i_row);
            end
        end
        if (i_frame_end) begin
            res.pos = have_min_shadow ? min_pos_shadow : 11'd0;
            res.sum = have_min_shadow ? min_sum_shadow : 24'd0;
            res.found = have_min_shadow;
            best_line_q.push_back(res);
            row_sum_shadow = 0;
            min_sum_shadow = 24'hFFFFFF;
            min_pos_shadow = 0;
            have_min_shadow = 0;
        end
    endtask

    // accepted requests, config writes and results, all sampled at the rising edge
    always @(posedge i_clk) begin
        pixel_taken <= i_valid && !o_stall && i_rst_n;
        cfg_taken <= i_cfg_valid && o_cfg_ready && i_rst_n;
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                if (best_line_q.size() == 0) begin
                    report_mismatch("unexpected result pos", o_best_pos, 0);
                end else begin
                    if (o_best_pos !== best_line_q[0].pos)
                        report_mismatch("best_pos", o_best_pos, best_line_q[0].pos);
                    if (o_best_sum !== best_line_q[0].sum)
                        report_mismatch("best_sum", o_best_sum, best_line_q[0].sum);
                    if (o_found !== best_line_q[0].found)
                        report_mismatch("found", o_found, best_line_q[0].found);
                    void'(best_line_q.pop_front());
                end
            end
            if (i_cfg_valid && o_cfg_ready) begin
                case (t_reg_idx'(i_cfg_index))
                    REG_REF_L: cfg_shadow.ref_l = i_cfg_data[7:0];
                    REG_REF_A: cfg_shadow.ref_a = i_cfg_data[7:0];
                    REG_REF_B: cfg_shadow.ref_b = i_cfg_data[7:0];
                    REG_WXF:   cfg_shadow.wxf = i_cfg_data[10:0];
                    REG_WXE:   cfg_shadow.wxe = i_cfg_data;
                    REG_WYF:   cfg_shadow.wyf = i_cfg_data[10:0];
                    REG_WYE:   cfg_shadow.wye = i_cfg_data;
                    REG_MODE:  cfg_shadow.mode = i_cfg_data[0];
                    default: ;
                endcase
            end
            if (i_valid && !o_stall) apply_pixel();
        end
    end

    // receiver: random stall, or a long hold-off while hold_left runs down
    initial begin
        i_stall = 0;
        forever begin
            @(negedge i_clk);
            if (hold_left > 0) begin
                i_stall = 1;
                hold_left--;
            end else begin
                i_stall = ($urandom_range(99) < stall_pct);
            end
        end
    end

    task automatic wait_results_done();
        while (best_line_q.size() != 0) @(negedge i_clk);
        repeat (40) @(negedge i_clk);
    endtask

    task automatic write_reg(input t_reg_idx idx, input logic [11:0] data);
        wait_results_done();
        i_cfg_valid = 1;
        i_cfg_index = idx;
        i_cfg_data = data;
        do @(negedge i_clk); while (!cfg_taken);
        i_cfg_valid = 0;
    endtask

    task automatic set_ref(input logic [7:0] l, input logic [7:0] a, input logic [7:0] b);
        write_reg(REG_REF_L, {4'd0, l});
        write_reg(REG_REF_A, {4'd0, a});
        write_reg(REG_REF_B, {4'd0, b});
    endtask

    task automatic set_window(input int xf, input int xe, input int yf, input int ye,
                              input bit mode);
        write_reg(REG_WXF, xf[11:0]);
        write_reg(REG_WXE, xe[11:0]);
        write_reg(REG_WYF, yf[11:0]);
        write_reg(REG_WYE, ye[11:0]);
        write_reg(REG_MODE, {11'd0, mode});
    endtask

    task automatic send_pixel(input logic [7:0] l, input logic [7:0] a, input logic [7:0] b,
                              input logic [10:0] c, input logic [10:0] r, input bit fend);
        // never add into a column sum that was not started
        if (!cfg_shadow.mode && in_window(c, r) && r != cfg_shadow.wyf && !col_written[c])
            r = cfg_shadow.wyf;
        while ($urandom_range(99) < sender_idle_pct) begin
            i_valid = 0;
            @(negedge i_clk);
        end
        i_valid = 1;
        i_pix_l = l;
        i_pix_a = a;
        i_pix_b = b;
        i_col = c;
        i_row = r;
        i_frame_end = fend;
        do @(negedge i_clk); while (!pixel_taken);
        i_valid = 0;
        pixels_sent++;
    endtask

    // raster frame over a rectangle, colors random or one fixed color
    task automatic send_frame(input int x0, input int w, input int y0, input int h,
                              input bit uniform, input logic [7:0] ul);
        for (int r = y0; r < y0 + h; r++)
            for (int c = x0; c < x0 + w; c++)
                if (uniform)
                    send_pixel(ul, ul, ul, c, r, (r == y0 + h - 1) && (c == x0 + w - 1));
                else
                    send_pixel($urandom, $urandom, $urandom, c, r,
                               (r == y0 + h - 1) && (c == x0 + w - 1));
    endtask

    task automatic random_frame();
        int xf, yf, w, h, x0, y0;
        bit mode;
        w = $urandom_range(5, 1);
        h = $urandom_range(4, 1);
        xf = $urandom_range(2048 - w);
        yf = $urandom_range(2048 - h);
        mode = $urandom_range(1);
        if ($urandom_range(3) == 0) set_ref($urandom, $urandom, $urandom);
        set_window(xf, xf + w, yf, yf + h, mode);
        x0 = (xf > 0) ? xf - $urandom_range(1) : xf;
        y0 = (yf > 0) ? yf - $urandom_range(1) : yf;
        send_frame(x0, w + (xf - x0) + $urandom_range(1), y0, h + (yf - y0),
                   $urandom_range(7) == 0, $urandom);
        if ($urandom_range(5) == 0) begin
            repeat ($urandom_range(4, 1))
                send_pixel($urandom, $urandom, $urandom, $urandom, $urandom,
                           $urandom_range(3) == 0);
        end
    endtask

    task automatic test_defaults();
        // default window ends past the coordinates: nothing completes
        send_frame(0, 2, 0, 2, 0, 0);
    endtask

    task automatic test_color_extremes();
        set_ref(8'd255, 8'd0, 8'd255);
        set_window(0, 2, 0, 2, 0);
        send_pixel(0, 255, 0, 0, 0, 0);
        send_pixel(255, 0, 255, 1, 0, 0);
        send_pixel(128, 128, 128, 0, 1, 0);
        send_pixel(255, 0, 255, 1, 1, 1);
        set_ref(8'd0, 8'd0, 8'd0);
    endtask

    task automatic test_high_corner();
        set_window(2046, 2048, 2046, 2048, 1);
        send_frame(2046, 2, 2046, 2, 0, 0);
        write_reg(REG_MODE, 12'd0);
        send_frame(2046, 2, 2046, 2, 0, 0);
    endtask

    task automatic test_tie_and_empty();
        set_window(3, 6, 7, 8, 0);
        send_frame(3, 3, 7, 1, 1, 8'd90);
        set_window(9, 9, 0, 4, 1);
        send_frame(8, 2, 0, 1, 0, 0);
        set_window(9, 4, 5, 2, 0);
        send_frame(3, 2, 4, 1, 0, 0);
    endtask

    task automatic test_random_phase(input int idle_pct, input int rx_pct, input int items);
        int target;
        sender_idle_pct = idle_pct;
        stall_pct = rx_pct;
        target = pixels_sent + items;
        while (pixels_sent < target) random_frame();
    endtask

    task automatic test_backpressure();
        sender_idle_pct = 0;
        stall_pct = 0;
        set_window(0, 2, 0, 1, 1);
        hold_left = 300;
        repeat (12) send_frame(0, 2, 0, 1, 0, 0);
        wait_results_done();
        send_frame(0, 2, 0, 1, 0, 0);
    endtask

    initial begin
        cfg_shadow = '{ref_l: 0, ref_a: 0, ref_b: 0, wxf: 0, wxe: 12'd2048, wyf: 0,
                       wye: 12'd2048, mode: 0};
        row_sum_shadow = 0;
        min_sum_shadow = 24'hFFFFFF;
        min_pos_shadow = 0;
        have_min_shadow = 0;
        i_rst_n = 0;
        i_valid = 0;
        i_pix_l = 0;
        i_pix_a = 0;
        i_pix_b = 0;
        i_col = 0;
        i_row = 0;
        i_frame_end = 0;
        i_cfg_valid = 0;
        i_cfg_index = REG_REF_L;
        i_cfg_data = 0;
        repeat (8) @(negedge i_clk);
        i_rst_n = 1;
        @(negedge i_clk);
        test_defaults();
        test_color_extremes();
        test_high_corner();
        test_tie_and_empty();
        test_random_phase(31, 56, 200);
        test_random_phase(56, 31, 200);
        test_backpressure();
        test_random_phase(0, 0, 200);
        wait_results_done();
        if (mismatch_count == 0)
            $display("color_distance_projection_argmin verification clean");
        else
            $display("color_distance_projection_argmin verification failed");
        $finish;
    end
endmodule
